@@ hdl/bpa_pkg.sv @@
// Shared types, codes and a helper function for the buddy page allocator.
`default_nettype none
package bpa_pkg;

  localparam int ORD_W  = 4;
  localparam int ST_W   = 2;
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_INVALID = 2'd2
  } st_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_CLR,
    DP_SRCH_NEXT,
    DP_FOUND,
    DP_SPLIT,
    DP_CHK_NEXT,
    DP_MRG_INIT,
    DP_MRG_UP,
    DP_MRG_SET,
    DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   rd_idx;
    st_t    res;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic bad_order;
    logic bad_free;
    logic word_nz;
    logic srch_last;
    logic j_max;
    logic j_is_ord;
    logic chk_hit;
    logic chk_last;
    logic buddy_free;
  } stat_t;

  // Position of the lowest set bit of a bitmap word.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/buddy_page_allocator.sv @@
// Top level of the buddy page allocator.
// Requests arrive as words on the input channel (in_valid/in_ready): an opcode
// (allocate or free), an order and, for a free, the block's first page. Each
// request yields exactly one word on the output channel (out_valid/out_ready):
// a status and, for a successful allocation, the first page of the block.
// The free bitmaps of all orders live in one memory of 64-bit words with a
// registered read, and every bitmap access is a read followed by a step that
// evaluates the word and writes it back. An allocation scans bitmap words
// from the requested order upwards, then splits one level at a time; a free
// checks for overlap across all orders, then merges upwards. Requests are
// handled one at a time. After reset the block sweeps the bitmap memory, one
// word a cycle, leaving only the top-order blocks free; in_ready stays low
// meanwhile. A finished word waits in the output register while the receiver
// stalls; the next request is still taken, and its word waits until the
// register empties.
`default_nettype none
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int MAX_ORDER  = 10,
  parameter int TOP_BLOCKS = 3,
  localparam int ADDR_W    = $clog2(TOP_BLOCKS << MAX_ORDER)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              opcode,
  input  wire logic [ORD_W-1:0]  request_order,
  input  wire logic [ADDR_W-1:0] block_address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ST_W-1:0]        status,
  output logic [ADDR_W-1:0]      allocated_address
);

  cmd_t  cmd;
  stat_t stat;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpa_datapath #(
    .MAX_ORDER  (MAX_ORDER),
    .TOP_BLOCKS (TOP_BLOCKS),
    .ADDR_W     (ADDR_W)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .opcode            (opcode),
    .request_order     (request_order),
    .block_address     (block_address),
    .status            (status),
    .allocated_address (allocated_address)
  );

endmodule
`default_nettype wire

@@ hdl/bpa_datapath.sv @@
// Datapath of the buddy page allocator: free bitmaps, cursors and result word.
`default_nettype none
module bpa_datapath
  import bpa_pkg::*;
#(
  parameter int MAX_ORDER  = 10,
  parameter int TOP_BLOCKS = 3,
  parameter int ADDR_W     = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  input  wire logic              opcode,
  input  wire logic [ORD_W-1:0]  request_order,
  input  wire logic [ADDR_W-1:0] block_address,
  output logic [ST_W-1:0]        status,
  output logic [ADDR_W-1:0]      allocated_address
);

  localparam int TOTAL = TOP_BLOCKS << MAX_ORDER;
  localparam int WORDS = (TOTAL + WORD_W - 1) / WORD_W;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int JW    = $clog2(MAX_ORDER + 1);
  localparam int XW    = ADDR_W + BIT_W;
  localparam int DEPTH = (MAX_ORDER + 1) << WW;
  localparam logic [XW-1:0]     LAST_PAGE = XW'(TOTAL - 1);
  localparam logic [WORD_W-1:0] TOP_MASK  = (WORD_W'(1) << TOP_BLOCKS) - WORD_W'(1);

  // One bitmap region per order, each sized for the order-0 bitmap rounded up to a power of two words.
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [JW+WW-1:0]  mem_a;
  logic              we;
  logic [WORD_W-1:0] wdata;

  logic [JW-1:0]     j_q, j_next;
  logic [WW-1:0]     w_q, w_next;
  logic [ORD_W-1:0]  ord_q, ord_next;
  logic [ADDR_W-1:0] addr_q, addr_next;
  logic [ADDR_W-1:0] idx_q, idx_next;
  logic              op_q, op_next;
  logic [ST_W-1:0]   status_q;
  logic [ADDR_W-1:0] alloc_q;

  logic [JW-1:0]     j_inc;
  logic [XW-1:0]     addr_x, last_x, lo_x, hi_x, lo_inc_x, idx_x, end_x, found_x, in_x;
  logic [WW-1:0]     lo_w, hi_w, idx_w, srch_end;
  logic [BIT_W-1:0]  lo_b, hi_b, idx_b, lsb;
  logic [WORD_W-1:0] mask;
  logic [ADDR_W:0]   in_sz, in_end;
  logic [ADDR_W:0]   in_sz_m1;

  assign j_inc    = j_q + JW'(1);
  assign addr_x   = XW'(addr_q);
  assign last_x   = addr_x + (XW'(1) << ord_q) - XW'(1);
  assign lo_x     = addr_x >> j_q;
  assign hi_x     = last_x >> j_q;
  assign lo_inc_x = addr_x >> j_inc;
  assign end_x    = LAST_PAGE >> j_q;
  assign idx_x    = XW'(idx_q);
  assign lo_w     = lo_x[WW+BIT_W-1:BIT_W];
  assign hi_w     = hi_x[WW+BIT_W-1:BIT_W];
  assign idx_w    = idx_x[WW+BIT_W-1:BIT_W];
  assign idx_b    = idx_x[BIT_W-1:0];
  assign srch_end = end_x[WW+BIT_W-1:BIT_W];
  assign lo_b     = (w_q == lo_w) ? lo_x[BIT_W-1:0] : '0;
  assign hi_b     = (w_q == hi_w) ? hi_x[BIT_W-1:0] : '1;
  assign mask     = ({WORD_W{1'b1}} << lo_b) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_b));
  assign lsb      = lowest_set(rdata);
  assign found_x  = XW'({w_q, lsb}) << j_q;
  assign in_x     = XW'(block_address);

  assign in_sz    = (ADDR_W + 1)'(1) << request_order;
  assign in_sz_m1 = in_sz - (ADDR_W + 1)'(1);
  assign in_end   = {1'b0, block_address} + in_sz;

  assign mem_a = cmd.rd_idx ? {j_q, idx_w} : {j_q, w_q};

  always_comb begin
    stat.clr_done   = (j_q == JW'(MAX_ORDER)) && (&w_q);
    stat.is_free    = (opcode == OP_FREE);
    stat.bad_order  = request_order > ORD_W'(MAX_ORDER);
    stat.bad_free   = (|(block_address & in_sz_m1[ADDR_W-1:0])) ||
                      (in_end > (ADDR_W + 1)'(TOTAL));
    stat.word_nz    = |rdata;
    stat.srch_last  = (w_q == srch_end);
    stat.j_max      = (j_q == JW'(MAX_ORDER));
    stat.j_is_ord   = (ORD_W'(j_q) == ord_q);
    stat.chk_hit    = |(rdata & mask);
    stat.chk_last   = (w_q == hi_w);
    stat.buddy_free = rdata[idx_b ^ BIT_W'(1)];
  end

  always_comb begin
    j_next    = j_q;
    w_next    = w_q;
    ord_next  = ord_q;
    addr_next = addr_q;
    idx_next  = idx_q;
    op_next   = op_q;
    we        = 1'b0;
    wdata     = rdata;
    unique case (cmd.op)
      DP_LOAD: begin
        ord_next  = request_order;
        addr_next = block_address;
        op_next   = opcode;
        j_next    = (opcode == OP_FREE) ? '0 : JW'(request_order);
        w_next    = (opcode == OP_FREE) ? in_x[WW+BIT_W-1:BIT_W] : '0;
      end
      DP_CLR: begin
        we     = 1'b1;
        wdata  = (j_q == JW'(MAX_ORDER) && w_q == '0) ? TOP_MASK : '0;
        w_next = w_q + WW'(1);
        if (&w_q) j_next = j_inc;
      end
      DP_SRCH_NEXT: begin
        if (stat.srch_last) begin
          j_next = j_inc;
          w_next = '0;
        end else begin
          w_next = w_q + WW'(1);
        end
      end
      DP_FOUND: begin
        // Take the block, then point at the upper half one order down.
        we        = 1'b1;
        wdata     = rdata & ~(WORD_W'(1) << lsb);
        addr_next = found_x[ADDR_W-1:0];
        j_next    = j_q - JW'(1);
        idx_next  = ADDR_W'({w_q, lsb, 1'b1});
      end
      DP_SPLIT: begin
        we       = 1'b1;
        wdata    = rdata | (WORD_W'(1) << idx_b);
        j_next   = j_q - JW'(1);
        idx_next = ADDR_W'(((idx_x >> 1) << 2) | XW'(1));
      end
      DP_CHK_NEXT: begin
        if (stat.chk_last) begin
          j_next = j_inc;
          w_next = lo_inc_x[WW+BIT_W-1:BIT_W];
        end else begin
          w_next = w_q + WW'(1);
        end
      end
      DP_MRG_INIT: begin
        j_next   = JW'(ord_q);
        idx_next = ADDR_W'(addr_x >> ord_q);
      end
      DP_MRG_UP: begin
        we       = 1'b1;
        wdata    = rdata & ~(WORD_W'(1) << (idx_b ^ BIT_W'(1)));
        idx_next = idx_q >> 1;
        j_next   = j_inc;
      end
      DP_MRG_SET: begin
        we    = 1'b1;
        wdata = rdata | (WORD_W'(1) << idx_b);
      end
      DP_NONE, DP_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j_q <= '0;
      w_q <= '0;
    end else begin
      j_q <= j_next;
      w_q <= w_next;
    end
  end

  always_ff @(posedge clk) begin
    ord_q  <= ord_next;
    addr_q <= addr_next;
    idx_q  <= idx_next;
    op_q   <= op_next;
    if (cmd.op == DP_RESULT) begin
      status_q <= cmd.res;
      alloc_q  <= (cmd.res == ST_OK && op_q == OP_ALLOC) ? addr_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[mem_a];
    if (we) mem[mem_a] <= wdata;
  end

  assign status            = status_q;
  assign allocated_address = alloc_q;

endmodule
`default_nettype wire

@@ hdl/bpa_ctrl.sv @@
// Controller of the buddy page allocator: sequences search, split, check and merge.
`default_nettype none
module bpa_ctrl
  import bpa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [10:0] {
    S_CLR  = 11'b000_0000_0001,
    S_IDLE = 11'b000_0000_0010,
    S_SRD  = 11'b000_0000_0100,
    S_SEV  = 11'b000_0000_1000,
    S_PRD  = 11'b000_0001_0000,
    S_PEV  = 11'b000_0010_0000,
    S_CRD  = 11'b000_0100_0000,
    S_CEV  = 11'b000_1000_0000,
    S_MRD  = 11'b001_0000_0000,
    S_MEV  = 11'b010_0000_0000,
    S_RESP = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  st_t    res, res_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    res_next       = res;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = DP_NONE;
    cmd.rd_idx     = 1'b0;
    cmd.res        = res;
    unique case (state)
      S_CLR: begin
        cmd.op = DP_CLR;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_LOAD;
          priority if (stat.bad_order) begin
            res_next   = ST_INVALID;
            state_next = S_RESP;
          end else if (!stat.is_free) begin
            state_next = S_SRD;
          end else if (stat.bad_free) begin
            res_next   = ST_INVALID;
            state_next = S_RESP;
          end else begin
            state_next = S_CRD;
          end
        end
      end
      S_SRD: state_next = S_SEV;
      S_SEV: begin
        if (stat.word_nz) begin
          cmd.op = DP_FOUND;
          if (stat.j_is_ord) begin
            res_next   = ST_OK;
            state_next = S_RESP;
          end else begin
            state_next = S_PRD;
          end
        end else if (stat.srch_last && stat.j_max) begin
          res_next   = ST_NOMEM;
          state_next = S_RESP;
        end else begin
          cmd.op     = DP_SRCH_NEXT;
          state_next = S_SRD;
        end
      end
      S_PRD: begin
        cmd.rd_idx = 1'b1;
        state_next = S_PEV;
      end
      S_PEV: begin
        cmd.rd_idx = 1'b1;
        cmd.op     = DP_SPLIT;
        if (stat.j_is_ord) begin
          res_next   = ST_OK;
          state_next = S_RESP;
        end else begin
          state_next = S_PRD;
        end
      end
      S_CRD: state_next = S_CEV;
      S_CEV: begin
        if (stat.chk_hit) begin
          res_next   = ST_INVALID;
          state_next = S_RESP;
        end else if (stat.chk_last && stat.j_max) begin
          cmd.op     = DP_MRG_INIT;
          state_next = S_MRD;
        end else begin
          cmd.op     = DP_CHK_NEXT;
          state_next = S_CRD;
        end
      end
      S_MRD: begin
        cmd.rd_idx = 1'b1;
        state_next = S_MEV;
      end
      S_MEV: begin
        cmd.rd_idx = 1'b1;
        if (!stat.j_max && stat.buddy_free) begin
          cmd.op     = DP_MRG_UP;
          state_next = S_MRD;
        end else begin
          cmd.op     = DP_MRG_SET;
          res_next   = ST_OK;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        // Wait here only while the previous word still sits in the output register.
        if (!out_valid || out_ready) begin
          cmd.op         = DP_RESULT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      res       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res       <= res_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire
